@@ sv/u8t_pkg.sv @@
`default_nettype none

package u8t_pkg;

    localparam int unsigned IDX_W = 7;

    typedef enum logic [1:0] {
        CMD_DATA  = 2'd0,
        CMD_TITLE = 2'd1,
        CMD_SUB   = 2'd2,
        CMD_DEV   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_LEAD      = 3'd1,
        ERR_SURROGATE = 3'd2,
        ERR_BEYOND    = 3'd3,
        ERR_LONG      = 3'd4,
        ERR_ORDER     = 3'd5,
        ERR_TRUNC     = 3'd6
    } t_err;

    localparam logic [15:0] UNIT_NEWLINE = 16'h000A;
    localparam logic [15:0] SURR_LO      = 16'hD800;
    localparam logic [15:0] SURR_HI      = 16'hDFFF;
    localparam logic [7:0]  LEAD4_MAX    = 8'hF4;
    localparam logic [7:0]  MASK_BASE    = 8'h3F;
    localparam logic [7:0]  MASK_CN      = 8'h40;
    localparam logic [7:0]  MASK_KR      = 8'h80;

    localparam logic [2:0] REG_VERSION = 3'd0;
    localparam logic [1:0] VERSION_RST = 2'd1;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] data_byte;
        logic       part_end;
    } t_in;

    typedef struct packed {
        logic             char_valid;
        logic [IDX_W-1:0] char_index;
        logic [15:0]      code_unit;
        logic [7:0]       language_mask;
        t_err             error_code;
    } t_out;

    typedef struct packed {
        logic [15:0] pending_bits;
        logic [1:0]  bytes_left;
        logic        subtitle_seen;
        logic        developer_seen;
        logic        error_latched;
    } t_dec_state;

endpackage

`default_nettype wire

@@ sv/u8t_if.sv @@
`default_nettype none

interface u8t_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       part_end;

    modport source (output valid, output command, output data_byte, output part_end,
                    input ready);
    modport sink (input valid, input command, input data_byte, input part_end,
                  output ready);
endinterface

interface u8t_out_if;
    logic        valid;
    logic        ready;
    logic        char_valid;
    logic [6:0]  char_index;
    logic [15:0] code_unit;
    logic [7:0]  language_mask;
    logic [2:0]  error_code;

    modport source (output valid, output char_valid, output char_index, output code_unit,
                    output language_mask, output error_code, input ready);
    modport sink (input valid, input char_valid, input char_index, input code_unit,
                  input language_mask, input error_code, output ready);
endinterface

`default_nettype wire

@@ sv/u8t_cfg.sv @@
`default_nettype none

module u8t_cfg
    import u8t_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [1:0]  o_version
);

    logic [1:0] r_version;
    logic       sel_version;

    assign sel_version = (paddr[2] == REG_VERSION[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= VERSION_RST;
        end else if (psel && penable && pwrite && sel_version) begin
            r_version <= pwdata[1:0];
        end
    end

    assign pready    = 1'b1;
    assign prdata    = sel_version ? {30'd0, r_version} : 32'd0;
    assign o_version = r_version;

endmodule

`default_nettype wire

@@ sv/u8t_step.sv @@
`default_nettype none

module u8t_step
    import u8t_pkg::*;
#(
    parameter int unsigned MAX_TITLE_UNITS = 128,
    parameter int unsigned CW = $clog2(MAX_TITLE_UNITS + 1)
) (
    input  t_in             i_item,
    input  t_dec_state      i_state,
    input  wire  [CW-1:0]   i_count,
    input  wire  [1:0]      i_version,
    output t_dec_state      o_state,
    output logic [CW-1:0]   o_count,
    output t_out            o_result
);

    localparam int unsigned IW = (CW < IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_TITLE_UNITS);

    logic        full;
    logic        emit;
    logic [15:0] unit;
    logic [15:0] merged;
    logic [7:0]  mask;
    t_err        err;
    logic [7:0]  b;

    assign b    = i_item.data_byte;
    assign full = (i_count >= MAX_C);

    always_comb begin
        mask = MASK_BASE;
        if (i_version > 2'd1) mask = mask | MASK_CN;
        if (i_version > 2'd2) mask = mask | MASK_KR;
    end

    assign merged = (i_state.bytes_left == 2'd2)
                  ? (i_state.pending_bits | {4'd0, b[5:0], 6'd0})
                  : (i_state.pending_bits | {10'd0, b[5:0]});

    always_comb begin
        o_state  = i_state;
        o_count  = i_count;
        o_result = '0;
        err      = ERR_NONE;
        emit     = 1'b0;
        unit     = '0;
        if (!i_state.error_latched) begin
            case (i_item.command)
                CMD_DATA: begin
                    if (i_state.bytes_left == 2'd0) begin
                        if (full) begin
                            err = ERR_LONG;
                        end else if (!b[7]) begin
                            emit = 1'b1;
                            unit = {8'd0, b};
                        end else if (b[7:5] == 3'b110) begin
                            o_state.pending_bits = {5'd0, b[4:0], 6'd0};
                            o_state.bytes_left   = 2'd1;
                            if (i_item.part_end) err = ERR_TRUNC;
                        end else if (b[7:4] == 4'b1110) begin
                            o_state.pending_bits = {b[3:0], 12'd0};
                            o_state.bytes_left   = 2'd2;
                            if (i_item.part_end) err = ERR_TRUNC;
                        end else if (b[7:3] == 5'b11110 && b <= LEAD4_MAX) begin
                            err = ERR_BEYOND;
                        end else begin
                            err = ERR_LEAD;
                        end
                    end else begin
                        o_state.pending_bits = merged;
                        o_state.bytes_left   = i_state.bytes_left - 2'd1;
                        if (i_state.bytes_left == 2'd1) begin
                            if (merged >= SURR_LO && merged <= SURR_HI) begin
                                err = ERR_SURROGATE;
                            end else begin
                                emit = 1'b1;
                                unit = merged;
                            end
                        end else if (i_item.part_end) begin
                            err = ERR_TRUNC;
                        end
                    end
                end
                CMD_TITLE: begin
                    if (i_state.bytes_left != 2'd0) begin
                        err = ERR_TRUNC;
                    end else if (i_count != '0) begin
                        err = ERR_ORDER;
                    end
                end
                CMD_SUB: begin
                    if (i_state.bytes_left != 2'd0) begin
                        err = ERR_TRUNC;
                    end else if (i_count == '0 || i_state.developer_seen
                                 || i_state.subtitle_seen) begin
                        err = ERR_ORDER;
                    end else begin
                        o_state.subtitle_seen = 1'b1;
                        if (full) begin
                            err = ERR_LONG;
                        end else begin
                            emit = 1'b1;
                            unit = UNIT_NEWLINE;
                        end
                    end
                end
                default: begin
                    if (i_state.bytes_left != 2'd0) begin
                        err = ERR_TRUNC;
                    end else if (i_count == '0 || i_state.developer_seen) begin
                        err = ERR_ORDER;
                    end else begin
                        o_state.developer_seen = 1'b1;
                        if (full) begin
                            err = ERR_LONG;
                        end else begin
                            emit = 1'b1;
                            unit = UNIT_NEWLINE;
                        end
                    end
                end
            endcase

            if (err != ERR_NONE) begin
                o_result.error_code   = err;
                o_state.error_latched = 1'b1;
            end else if (emit) begin
                o_count                = i_count + CW'(1);
                o_result.char_valid    = 1'b1;
                o_result.char_index    = IDX_W'(i_count[IW-1:0]);
                o_result.code_unit     = unit;
                o_result.language_mask = mask;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/utf8_title_to_utf16_writer_core.sv @@
// UTF-8 banner title decoder, writing BMP code units to the title slots.
// i_item: one beat per item (command, data_byte, part_end), valid/ready.
// o_res: one beat per accepted item (char_valid, char_index, code_unit,
//   language_mask, error_code); char_valid is 0 for lead and middle bytes,
//   start commands that write nothing, and errors.
// APB port: register 0 at byte address 0 holds banner_version (2 bits).
// The item sits in the input register, is decoded there, and its result
//   is registered into the result register that drives o_res.
// Throughput: one item per cycle while o_res does not stall; the decode
//   is a single pass over the input register and the small running state
//   (unit count, partial code point, bytes still due, part flags, error latch).
// When o_res stalls, the result register holds and the input register
//   fills; i_item.ready drops only once both are occupied.
// Reset empties both registers, clears the running state, and sets
//   banner_version to 1. An error latches until reset; later items give
//   all-zero results.
`default_nettype none

module utf8_title_to_utf16_writer_core
    import u8t_pkg::*;
#(
    parameter int unsigned MAX_TITLE_UNITS = 128
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    u8t_in_if.sink      i_item,
    u8t_out_if.source   o_res,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned CW = $clog2(MAX_TITLE_UNITS + 1);

    logic          r_in_valid;
    t_in           r_in;
    logic          r_out_valid;
    t_out          r_out;
    t_dec_state    r_state;
    logic [CW-1:0] r_count;

    t_dec_state    n_state;
    logic [CW-1:0] n_count;
    t_out          n_out;
    logic [1:0]    version;
    logic          advance;

    u8t_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_version (version)
    );

    u8t_step #(
        .MAX_TITLE_UNITS (MAX_TITLE_UNITS),
        .CW              (CW)
    ) u_step (
        .i_item    (r_in),
        .i_state   (r_state),
        .i_count   (r_count),
        .i_version (version),
        .o_state   (n_state),
        .o_count   (n_count),
        .o_result  (n_out)
    );

    assign advance      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.command   <= t_cmd'(i_item.command);
            r_in.data_byte <= i_item.data_byte;
            r_in.part_end  <= i_item.part_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.char_valid    = r_out.char_valid;
    assign o_res.char_index    = r_out.char_index;
    assign o_res.code_unit     = r_out.code_unit;
    assign o_res.language_mask = r_out.language_mask;
    assign o_res.error_code    = r_out.error_code;

    a_err_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.error_code != ERR_NONE |-> !r_out.char_valid)
        else $error("result carries both an error and a code unit");

    a_latched_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.error_latched |=> $stable(r_count) && r_state.error_latched)
        else $error("unit count moved after an error latched");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_out.char_valid |-> r_count < CW'(MAX_TITLE_UNITS))
        else $error("code unit written past the title limit");

endmodule

`default_nettype wire
